[hdl/cuckoo_hash_table_defines.svh]
// Assertion macros shared by the cuckoo hash table RTL.
`ifndef CUCKOO_HASH_TABLE_DEFINES_SVH
`define CUCKOO_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define CHT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cuckoo hash table check failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define CHT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cuckoo hash table check failed");

`endif

[hdl/cht_pkg.sv]
// Shared constants for the cuckoo hash table.
`default_nettype none
package cht_pkg;
   localparam int KEY_W  = 31;  // key and stored entry width
   localparam int CNT_W  = 5;   // divider step counter width
   localparam int CSR_W  = 10;  // slots_in_use register width
   localparam int DATA_W = 32;  // APB data width
   localparam int ADDR_W = 3;   // APB address width

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
endpackage
`default_nettype wire

[hdl/cht_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module cht_div
   import cht_pkg::*;
#(
   parameter int DW = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              go,
   input  wire logic [KEY_W-1:0]  numer,
   input  wire logic [DW-1:0]     denom,
   output logic                   done,
   output logic [KEY_W-1:0]       quotient,
   output logic [DW-1:0]          remainder
);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(KEY_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [KEY_W-1:0]  quo_ff, quo_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [DW:0]       trial;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[KEY_W-1]};
      ge      = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      done_in = busy_ff && (cnt_ff == LAST);
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = ge ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
         quo_in = {quo_ff[KEY_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

[hdl/cuckoo_hash_table.sv]
// Top level of the two-table cuckoo hash with its sequencer and table memories.
`default_nettype none
// Two-table cuckoo hash of positive 31-bit keys; a stored 0 is an empty slot.
// Issue a word with start while busy is low; exactly one response word comes
// back on rsp_status / rsp_dropped_key, flagged by rsp_valid for a single
// cycle. There is no back-pressure: the receiver must take it in that cycle.
// Hashing runs on the shared divider (one quotient bit per cycle). Search
// and remove take two divisions, a table read and a check before the next
// word is accepted. Insert of a key already present takes the same steps.
// Otherwise the first kick round adds a read-modify-write on table one, two
// divisions and a read-modify-write on table two, and each further round
// also runs one more division for the table-one slot; the insert ends early
// once a free slot is found. With MAX_KICKS = 2 at most two rounds are run.
// Key zero and the unused op code reply in the next cycle.
// After reset both tables are swept to zero, one entry per cycle, with busy
// held high until the sweep ends; CSR writes are taken meanwhile.
// slots_in_use (CSR at byte 0) is the hash modulus: 0 acts as 1 and values
// above SLOTS_PER_TABLE are clamped. Change it only while idle.
module cuckoo_hash_table
   import cht_pkg::*;
#(
   parameter int SLOTS_PER_TABLE = 512,
   parameter int MAX_KICKS       = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_operation,
   input  wire logic [KEY_W-1:0]  req_key,
   output logic                   rsp_valid,
   output logic                   rsp_status,
   output logic [KEY_W-1:0]       rsp_dropped_key,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0]      prdata,
   output logic                   pready
);
   localparam int IW = (SLOTS_PER_TABLE > 1) ? $clog2(SLOTS_PER_TABLE) : 1;
   localparam int DW = $clog2(SLOTS_PER_TABLE + 1);
   localparam int RW = $clog2(MAX_KICKS + 1);
   localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS_PER_TABLE - 1);

   typedef enum logic [13:0] {
      S_CLEAR = 14'b00000000000001,
      S_IDLE  = 14'b00000000000010,
      S_HASH1 = 14'b00000000000100,  // key / m
      S_HASH2 = 14'b00000000001000,  // (key / m) / m
      S_LOOK  = 14'b00000000010000,  // read both home slots
      S_CHECK = 14'b00000000100000,
      S_RD1   = 14'b00000001000000,
      S_WR1   = 14'b00000010000000,
      S_KB1   = 14'b00000100000000,  // evicted key / m
      S_KB2   = 14'b00001000000000,
      S_RD2   = 14'b00010000000000,
      S_WR2   = 14'b00100000000000,
      S_KA    = 14'b01000000000000,  // evicted key mod m
      S_SPARE = 14'b10000000000000   // never entered
   } state_type;

   // CSR
   logic [CSR_W-1:0] slots_ff, slots_in;
   logic             csr_wr;
   logic [DW-1:0]    modulus;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == 1'b0);
   assign prdata = DATA_W'(slots_ff);
   assign slots_in = csr_wr ? pwdata[CSR_W-1:0] : slots_ff;

   always_comb begin
      if (slots_ff == '0) begin
         modulus = DW'(1);
      end else if (32'(slots_ff) > 32'(SLOTS_PER_TABLE)) begin
         modulus = DW'(SLOTS_PER_TABLE);
      end else begin
         modulus = DW'(slots_ff);
      end
   end

   // Sequencer state
   state_type         state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  cur_ff, cur_in;
   logic [IW-1:0]     slot1_ff, slot1_in;
   logic [IW-1:0]     slot2_ff, slot2_in;
   logic [RW-1:0]     round_ff, round_in;
   logic [IW-1:0]     clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              status_ff, status_in;
   logic [KEY_W-1:0]  drop_ff, drop_in;

   // Tables
   logic [KEY_W-1:0]  table1_ff [SLOTS_PER_TABLE];
   logic [KEY_W-1:0]  table2_ff [SLOTS_PER_TABLE];
   logic [KEY_W-1:0]  t1_rd_ff, t2_rd_ff;
   logic [IW-1:0]     t1_addr, t2_addr;
   logic              t1_we, t2_we;
   logic [KEY_W-1:0]  t1_wdata, t2_wdata;

   // Shared divider
   logic              div_go, div_done;
   logic [KEY_W-1:0]  div_num, div_quo;
   logic [DW-1:0]     div_rem;
   logic              div_wait;

   cht_div #(.DW(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go),
      .numer     (div_num),
      .denom     (modulus),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // states that sit on the divider
   assign div_wait = (state_ff == S_HASH1) || (state_ff == S_HASH2) ||
                     (state_ff == S_KB1) || (state_ff == S_KB2) || (state_ff == S_KA);

   logic accept, in_one, in_two;
   assign accept = start && !busy;
   assign in_one = (t1_rd_ff == key_ff);
   assign in_two = (t2_rd_ff == key_ff);

   // both tables are always addressed by the held slots, except during the sweep
   assign t1_addr = (state_ff == S_CLEAR) ? clr_ff : slot1_ff;
   assign t2_addr = (state_ff == S_CLEAR) ? clr_ff : slot2_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      cur_in       = cur_ff;
      slot1_in     = slot1_ff;
      slot2_in     = slot2_ff;
      round_in     = round_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      drop_in      = drop_ff;
      div_go       = 1'b0;
      div_num      = req_key;
      t1_we        = 1'b0;
      t2_we        = 1'b0;
      t1_wdata     = '0;
      t2_wdata     = '0;
      unique case (state_ff)
         S_CLEAR: begin
            t1_we  = 1'b1;
            t2_we  = 1'b1;
            clr_in = clr_ff + IW'(1);
            if (clr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in  = req_operation;
               key_in = req_key;
               if (req_key == '0 || !(req_operation == OP_INSERT ||
                   req_operation == OP_SEARCH || req_operation == OP_REMOVE)) begin
                  // no-op word: answer right away
                  rsp_valid_in = 1'b1;
                  status_in    = 1'b0;
                  drop_in      = '0;
               end else begin
                  div_go   = 1'b1;
                  state_in = S_HASH1;
               end
            end
         end
         S_HASH1: begin
            div_num = div_quo;
            if (div_done) begin
               slot1_in = div_rem[IW-1:0];
               div_go   = 1'b1;
               state_in = S_HASH2;
            end
         end
         S_HASH2: begin
            if (div_done) begin
               slot2_in = div_rem[IW-1:0];
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            status_in = 1'b0;
            drop_in   = '0;
            state_in  = S_IDLE;
            priority case (op_ff)
               OP_SEARCH: begin
                  rsp_valid_in = 1'b1;
                  status_in    = in_one || in_two;
               end
               OP_REMOVE: begin
                  rsp_valid_in = 1'b1;
                  status_in    = in_one || in_two;
                  t1_we        = in_one;
                  t2_we        = !in_one && in_two;
               end
               default: begin
                  if (in_one || in_two) begin
                     rsp_valid_in = 1'b1;
                     status_in    = 1'b1;
                  end else begin
                     cur_in   = key_ff;
                     round_in = '0;
                     state_in = S_RD1;
                  end
               end
            endcase
         end
         S_RD1: begin
            state_in = S_WR1;
         end
         S_WR1: begin
            // place cur, pick up whatever sat there
            t1_we    = 1'b1;
            t1_wdata = cur_ff;
            cur_in   = t1_rd_ff;
            div_num  = t1_rd_ff;
            if (t1_rd_ff == '0) begin
               rsp_valid_in = 1'b1;
               status_in    = 1'b1;
               state_in     = S_IDLE;
            end else begin
               div_go   = 1'b1;
               state_in = S_KB1;
            end
         end
         S_KB1: begin
            div_num = div_quo;
            if (div_done) begin
               div_go   = 1'b1;
               state_in = S_KB2;
            end
         end
         S_KB2: begin
            if (div_done) begin
               slot2_in = div_rem[IW-1:0];
               state_in = S_RD2;
            end
         end
         S_RD2: begin
            state_in = S_WR2;
         end
         S_WR2: begin
            t2_we    = 1'b1;
            t2_wdata = cur_ff;
            cur_in   = t2_rd_ff;
            div_num  = t2_rd_ff;
            if (t2_rd_ff == '0) begin
               rsp_valid_in = 1'b1;
               status_in    = 1'b1;
               state_in     = S_IDLE;
            end else if (round_ff == RW'(MAX_KICKS - 1)) begin
               // out of kicks: the key still in hand is lost
               rsp_valid_in = 1'b1;
               status_in    = 1'b0;
               drop_in      = t2_rd_ff;
               state_in     = S_IDLE;
            end else begin
               round_in = round_ff + RW'(1);
               div_go   = 1'b1;
               state_in = S_KA;
            end
         end
         S_KA: begin
            if (div_done) begin
               slot1_in = div_rem[IW-1:0];
               state_in = S_RD1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         slots_ff     <= CSR_W'(512);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         slots_ff     <= slots_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      cur_ff    <= cur_in;
      slot1_ff  <= slot1_in;
      slot2_ff  <= slot2_in;
      status_ff <= status_in;
      drop_ff   <= drop_in;
   end

   always_ff @(posedge clock) begin
      if (t1_we) begin
         table1_ff[t1_addr] <= t1_wdata;
      end
      t1_rd_ff <= table1_ff[t1_addr];
   end

   always_ff @(posedge clock) begin
      if (t2_we) begin
         table2_ff[t2_addr] <= t2_wdata;
      end
      t2_rd_ff <= table2_ff[t2_addr];
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_dropped_key = drop_ff;

`include "cuckoo_hash_table_defines.svh"

   // every accepted word either starts the sequencer or replies next cycle
   `CHT_ASSERT_NEXT(a_accept_moves, accept, busy || rsp_valid)
   // the divider only finishes while the sequencer waits on it
   `CHT_ASSERT_NOW(a_div_expected, div_done, div_wait)
   // tables are never written while idle
   `CHT_ASSERT_NOW(a_no_idle_write, t1_we || t2_we, state_ff != S_IDLE)
   // a dropped key is only reported on a failed insert
   `CHT_ASSERT_NOW(a_drop_fail, rsp_valid && (rsp_dropped_key != '0), !rsp_status)
endmodule
`default_nettype wire
